### src/nlp_pkg.sv
// ----------------------------------------------------------------------------
// nlp_pkg: shared types and constants for permutation unranking
// Factorial function, digit pool type and per-stage payload.
// ----------------------------------------------------------------------------
package nlp_pkg;

    localparam int MaxSymbols = 10;
    localparam int RankW      = 22;
    localparam int PermW      = 34;
    localparam int DigitW     = 4;

    typedef logic [DigitW-1:0] t_digit;
    typedef t_digit [MaxSymbols-1:0] t_pool;

    // Factorials 0! .. 10!, all fit in the rank width.
    function automatic logic [RankW-1:0] fact(input int k);
        logic [RankW-1:0] f;
        f = RankW'(1);
        for (int m = 2; m <= MaxSymbols; m++) begin
            if (m <= k) begin
                f = RankW'(f * RankW'(m));
            end
        end
        return f;
    endfunction

    // Per-stage payload.
    typedef struct packed {
        logic             err;
        logic [RankW-1:0] rem;
        logic [PermW-1:0] value;
        t_pool            pool;
    } t_stage;

endpackage

### src/nth_lexicographic_permutation.sv
// ----------------------------------------------------------------------------
// nth_lexicographic_permutation: rank -> permutation of digits 0..N-1
// Factorial number system unranking, one digit position per pipeline stage.
// ----------------------------------------------------------------------------
// Channel | Dir | tdata fields (low bit up)          | tuser
// s_axis  | in  | rank[21:0]                         | -
// m_axis  | out | perm_value[33:0], zero pad to 40   | rank_error
//
// Stages: SYMBOL_COUNT+1 register stages (range check, then one digit per
// stage); the last digit stage is the output register. One request enters
// per cycle while the pipeline advances.
// Each digit stage finds its quotient by comparing the remainder against
// the multiples of a constant factorial (at most nine compares in parallel).
// Reset clears the stage valid bits only.
// Stall: the pipeline advances as a whole when the output is free or taken;
// s_axis_tready follows that.
// ----------------------------------------------------------------------------
module nth_lexicographic_permutation #(
    parameter int SYMBOL_COUNT = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // rank[21:0], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // perm_value[33:0], zero pad
    output logic        m_axis_tuser    // rank_error
);

    localparam int N = SYMBOL_COUNT;
    localparam int RW = nlp_pkg::RankW;

    // Stage 0 is the range check; stage k (1..N) places one digit.
    nlp_pkg::t_stage r_st [N+1];
    logic            r_vld [N+1];
    nlp_pkg::t_stage n_st [N+1];
    logic            adv;

    // Output register is r_st[N]; whole pipe moves when the end is free.
    assign adv           = !r_vld[N] || m_axis_tready;
    assign s_axis_tready = adv;

    always_comb begin
        logic [RW-1:0] rank;
        rank = s_axis_tdata[RW-1:0];
        n_st[0].err   = (rank == '0) || (rank > nlp_pkg::fact(N));
        n_st[0].rem   = RW'(rank - RW'(1));
        n_st[0].value = '0;
        for (int i = 0; i < nlp_pkg::MaxSymbols; i++) begin
            n_st[0].pool[i] = nlp_pkg::t_digit'(i);
        end
    end

    for (genvar k = 1; k <= N; k++) begin : g_dig
        localparam int Pos  = N - k;       // factorial index
        localparam int Left = N - k + 1;   // unused digits remaining
        always_comb begin
            nlp_pkg::t_stage s;
            logic [3:0] q;
            s = r_st[k-1];
            q = '0;
            // q = min(rem / Pos!, Left-1) by compares against multiples
            for (int m = 1; m < Left; m++) begin
                if ({2'b0, s.rem} >= (RW+2)'(m) * (RW+2)'(nlp_pkg::fact(Pos))) begin
                    q = 4'(m);
                end
            end
            n_st[k].err   = s.err;
            n_st[k].rem   = RW'({2'b0, s.rem} - (RW+2)'(q) * (RW+2)'(nlp_pkg::fact(Pos)));
            n_st[k].value = nlp_pkg::PermW'(s.value * nlp_pkg::PermW'(10))
                            + nlp_pkg::PermW'(s.pool[q]);
            n_st[k].pool  = s.pool;
            for (int j = 0; j < nlp_pkg::MaxSymbols - 1; j++) begin
                if (j >= q) begin
                    n_st[k].pool[j] = s.pool[j+1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_st[0] <= n_st[0];
            for (int k = 1; k <= N; k++) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= N; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (adv) begin
            r_vld[0] <= s_axis_tvalid;
            for (int k = 1; k <= N; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    assign m_axis_tvalid = r_vld[N];
    assign m_axis_tdata  = {6'b0, r_st[N].err ? nlp_pkg::PermW'(0) : r_st[N].value};
    assign m_axis_tuser  = r_st[N].err;

    // Unused upper input bits.
    logic unused_in;
    assign unused_in = ^s_axis_tdata[23:RW];

    // Stalled output must hold.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");
    // Error results carry zero value.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("error with nonzero value");
    // Ready only when the end stage is free or draining.
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("ready mismatch");

endmodule
